// ----- hdl/csse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csse_pkg
// Shared types, constants and fixed-point helpers of the cubic spline unit.
// ----------------------------------------------------------------------------
package csse_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 64;
  localparam int CNT_W       = 7;
  localparam int STEP_W      = 6;   // 64 serial steps per operation
  localparam int WORD_W      = 3 * DATA_W;

  localparam logic       KIND_LOAD = 1'b0;
  localparam logic       KIND_EVAL = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WIDTH = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic             sat;
  } sat_val_t;

  function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] x);
    return x[ACC_W-1] ? (~x + 64'd1) : x;
  endfunction

  function automatic sat_val_t sat_add(input logic [ACC_W-1:0] x,
                                       input logic [ACC_W-1:0] y);
    logic [ACC_W:0] s;
    sat_val_t       r;
    s = {x[ACC_W-1], x} + {y[ACC_W-1], y};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.sat = 1'b1;
      r.val = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // product magnitude -> rounded, signed, saturated fixed-point value
  function automatic sat_val_t fx_round(input logic [2*ACC_W-1:0] prod,
                                        input logic neg);
    logic [2*ACC_W-1:0] s;
    logic [ACC_W-1:0]   rlo;
    logic [ACC_W-1:0]   lim;
    logic               ovf;
    sat_val_t           r;
    s   = prod + ((2*ACC_W)'(1) << (FRAC_BITS - 1));
    rlo = s[FRAC_BITS +: ACC_W];
    ovf = |s[2*ACC_W-1:ACC_W+FRAC_BITS];
    lim = neg ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    if (ovf || (rlo > lim)) begin
      r.sat = 1'b1;
      r.val = lim;
    end else begin
      r.sat = 1'b0;
      r.val = neg ? (~rlo + 64'd1) : rlo;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/csse_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csse_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module csse_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/csse_arith.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csse_arith
// Bit-serial unsigned multiply (shift-add) and divide (restoring), one bit
// per cycle over 64 steps, sharing one pair of shift registers.
// ----------------------------------------------------------------------------
module csse_arith (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire csse_pkg::arith_req_t         req_i,
  input  wire logic [csse_pkg::ACC_W-1:0]   opa_i,
  input  wire logic [csse_pkg::ACC_W-1:0]   opb_i,
  output logic                              done_o,
  output logic [2*csse_pkg::ACC_W-1:0]      prod_o
);

  logic [csse_pkg::ACC_W-1:0]  hi_q, hi_d, lo_q, lo_d, opnd_q;
  logic [csse_pkg::STEP_W-1:0] cnt_q;
  logic                        busy_q, done_q;
  csse_pkg::arith_op_e         op_q;
  logic [csse_pkg::ACC_W:0]    sum;
  logic [csse_pkg::DATA_W:0]   trial;
  logic                        ge;

  always_comb begin
    sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opnd_q} : '0);
    trial = {hi_q[csse_pkg::DATA_W-1:0], lo_q[csse_pkg::ACC_W-1]};
    ge    = trial >= {1'b0, opnd_q[csse_pkg::DATA_W-1:0]};
    if (op_q == csse_pkg::OP_MUL) begin
      hi_d = sum[csse_pkg::ACC_W:1];
      lo_d = {sum[0], lo_q[csse_pkg::ACC_W-1:1]};
    end else begin
      // remainder stays below the 32-bit divisor
      hi_d = {{(csse_pkg::ACC_W-csse_pkg::DATA_W){1'b0}},
              ge ? trial[csse_pkg::DATA_W-1:0] - opnd_q[csse_pkg::DATA_W-1:0]
                 : trial[csse_pkg::DATA_W-1:0]};
      lo_d = {lo_q[csse_pkg::ACC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= csse_pkg::OP_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == '1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      if (req_i.op == csse_pkg::OP_MUL) begin
        lo_q   <= opb_i;
        opnd_q <= opa_i;
      end else begin
        lo_q   <= opa_i;
        opnd_q <= opb_i;
      end
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule
`default_nettype wire

// ----- hdl/cubic_spline_evaluator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_spline_evaluator_unit
// Knot table with bisection search and bit-serial cubic spline evaluation.
// ----------------------------------------------------------------------------
// A load item writes one knot (position, value, curvature) as it is accepted
// and returns nothing. An evaluate item returns one result: up to six
// bisection reads, each followed by a compare, reads of the two bracketing
// knots and a check of the interval width, then thirteen serial operations
// (two divides by the interval width, ten fixed-point multiplies and one
// divide by six) in the shared bit-serial multiply/divide unit; a width that
// is not positive skips them. One item is processed at a time; a finished
// result waits in the output register while the next item is taken.
module cubic_spline_evaluator_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // entry_index[5:0], knot_position[37:6], knot_value[69:38],
  // knot_curvature[101:70], eval_point[133:102], zero padding[135:134]
  input  wire logic [135:0] s_axis_tdata,
  // kind[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // spline_result[31:0]
  output logic [31:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser,
  input  wire logic         cfg_we_i,
  input  wire logic [6:0]   cfg_wdata_i
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_BIS  = 20'h00002,
    S_CMP  = 20'h00004,
    S_RLO  = 20'h00008,
    S_RHI  = 20'h00010,
    S_CHK  = 20'h00020,
    S_DIVA = 20'h00040,
    S_DIVB = 20'h00080,
    S_AA   = 20'h00100,
    S_AAA  = 20'h00200,
    S_BB   = 20'h00400,
    S_BBB  = 20'h00800,
    S_TLO  = 20'h01000,
    S_THI  = 20'h02000,
    S_HH   = 20'h04000,
    S_TH   = 20'h08000,
    S_DIV6 = 20'h10000,
    S_LLO  = 20'h20000,
    S_LHI  = 20'h40000,
    S_FIN  = 20'h80000
  } state_e;

  localparam int AW = csse_pkg::ADDR_W;
  localparam int DW = csse_pkg::DATA_W;
  localparam int XW = csse_pkg::ACC_W;

  state_e state_q, state_d;
  logic   issue_q, issue_d;

  logic [csse_pkg::CNT_W-1:0] n_q, n_clamp, hi_init;
  logic [AW-1:0] lo_q, hi_q, mid;
  logic [AW:0]   mid_sum;

  logic signed [DW-1:0] p_q, xlo_q, xhi_q, ylo_q, yhi_q, clo_q, chi_q;
  logic [DW-1:0]        h_q;
  logic [XW-1:0]        a_q, b_q, m_q, ca_q, cb_q, t_q;
  logic                 sat_q, bad_q;
  logic                 out_valid_q;
  logic [DW-1:0]        out_data_q;
  logic [1:0]           out_stat_q;

  logic [AW-1:0]             raddr;
  logic [csse_pkg::WORD_W-1:0] rdata;
  logic signed [DW-1:0]      rpos;
  logic                      s_accept, we;

  logic [AW-1:0] in_idx;
  logic [DW-1:0] in_pos, in_val, in_curv, in_pt;

  csse_pkg::arith_req_t    req;
  logic [XW-1:0]           opa, opb, x_op, y_op;
  logic                    neg, is_op, done;
  logic [2*XW-1:0]         prod;
  csse_pkg::sat_val_t      fx, sa;
  logic [XW-1:0]           sq, add_x, add_y;
  logic [DW:0]             diff, dmag, h33;
  logic                    clamp_hi, clamp_lo;

  assign in_idx  = s_axis_tdata[5:0];
  assign in_pos  = s_axis_tdata[37:6];
  assign in_val  = s_axis_tdata[69:38];
  assign in_curv = s_axis_tdata[101:70];
  assign in_pt   = s_axis_tdata[133:102];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign we            = s_accept && (s_axis_tuser[0] == csse_pkg::KIND_LOAD);

  always_comb begin
    if (n_q < 7'd2) begin
      n_clamp = 7'd2;
    end else if (n_q > 7'(csse_pkg::TABLE_DEPTH)) begin
      n_clamp = 7'(csse_pkg::TABLE_DEPTH);
    end else begin
      n_clamp = n_q;
    end
    hi_init = n_clamp - 7'd1;
  end

  assign mid_sum = {1'b0, hi_q} + {1'b0, lo_q};
  assign mid     = mid_sum[AW:1];
  assign rpos    = rdata[DW-1:0];

  always_comb begin
    unique case (state_q)
      S_BIS:   raddr = ((hi_q - lo_q) > 6'd1) ? mid : lo_q;
      S_RLO:   raddr = hi_q;
      default: raddr = lo_q;
    endcase
  end

  csse_ram #(
    .Width(csse_pkg::WORD_W),
    .Depth(csse_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(in_idx),
    .wdata_i({in_curv, in_val, in_pos}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // operand selection for the serial unit
  always_comb begin
    diff = (state_q == S_DIVA) ? ({xhi_q[DW-1], xhi_q} - {p_q[DW-1], p_q})
                               : ({p_q[DW-1], p_q} - {xlo_q[DW-1], xlo_q});
    dmag = diff[DW] ? (~diff + 1'b1) : diff;
    x_op = a_q;
    y_op = a_q;
    is_op = 1'b1;
    unique case (state_q)
      S_AA:    begin x_op = a_q;  y_op = a_q; end
      S_AAA:   begin x_op = m_q;  y_op = a_q; end
      S_BB:    begin x_op = b_q;  y_op = b_q; end
      S_BBB:   begin x_op = m_q;  y_op = b_q; end
      S_TLO:   begin x_op = ca_q; y_op = XW'(clo_q); end
      S_THI:   begin x_op = cb_q; y_op = XW'(chi_q); end
      S_HH:    begin x_op = {32'd0, h_q}; y_op = {32'd0, h_q}; end
      S_TH:    begin x_op = t_q;  y_op = m_q; end
      S_LLO:   begin x_op = a_q;  y_op = XW'(ylo_q); end
      S_LHI:   begin x_op = b_q;  y_op = XW'(yhi_q); end
      S_DIVA, S_DIVB, S_DIV6: ;
      default: is_op = 1'b0;
    endcase
    unique case (state_q)
      S_DIVA, S_DIVB: begin
        opa = XW'(dmag) << csse_pkg::FRAC_BITS;
        opb = {32'd0, h_q};
        neg = diff[DW];
        req.op = csse_pkg::OP_DIV;
      end
      S_DIV6: begin
        opa = csse_pkg::mag64(t_q);
        opb = 64'd6;
        neg = t_q[XW-1];
        req.op = csse_pkg::OP_DIV;
      end
      default: begin
        opa = csse_pkg::mag64(x_op);
        opb = csse_pkg::mag64(y_op);
        neg = x_op[XW-1] ^ y_op[XW-1];
        req.op = csse_pkg::OP_MUL;
      end
    endcase
    req.start = is_op && issue_q;
  end

  csse_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .opa_i (opa),
    .opb_i (opb),
    .done_o(done),
    .prod_o(prod)
  );

  assign fx = csse_pkg::fx_round(prod, neg);
  assign sq = neg ? (~prod[XW-1:0] + 64'd1) : prod[XW-1:0];

  always_comb begin
    unique case (state_q)
      S_AAA:   begin add_x = fx.val; add_y = ~a_q + 64'd1; end
      S_BBB:   begin add_x = fx.val; add_y = ~b_q + 64'd1; end
      S_THI:   begin add_x = m_q;    add_y = fx.val; end
      S_LHI:   begin add_x = m_q;    add_y = fx.val; end
      default: begin add_x = m_q;    add_y = t_q; end
    endcase
  end

  assign sa       = csse_pkg::sat_add(add_x, add_y);
  assign h33      = {xhi_q[DW-1], xhi_q} - {xlo_q[DW-1], xlo_q};
  assign clamp_hi = !sa.val[XW-1] && (sa.val[XW-2:DW-1] != '0);
  assign clamp_lo = sa.val[XW-1] && (sa.val[XW-2:DW-1] != '1);

  always_comb begin
    state_d = state_q;
    issue_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (s_accept && (s_axis_tuser[0] == csse_pkg::KIND_EVAL)) begin
        state_d = S_BIS;
      end
      S_BIS:  state_d = ((hi_q - lo_q) > 6'd1) ? S_CMP : S_RLO;
      S_CMP:  state_d = S_BIS;
      S_RLO:  state_d = S_RHI;
      S_RHI:  state_d = S_CHK;
      S_CHK: begin
        if (h33[DW] || (h33 == '0)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIVA;
          issue_d = 1'b1;
        end
      end
      S_DIVA, S_DIVB, S_AA, S_AAA, S_BB, S_BBB, S_TLO, S_THI, S_HH, S_TH,
      S_DIV6, S_LLO, S_LHI: begin
        if (done && !issue_q) begin
          issue_d = 1'b1;
          unique case (state_q)
            S_DIVA:  state_d = S_DIVB;
            S_DIVB:  state_d = S_AA;
            S_AA:    state_d = S_AAA;
            S_AAA:   state_d = S_BB;
            S_BB:    state_d = S_BBB;
            S_BBB:   state_d = S_TLO;
            S_TLO:   state_d = S_THI;
            S_THI:   state_d = S_HH;
            S_HH:    state_d = S_TH;
            S_TH:    state_d = S_DIV6;
            S_DIV6:  state_d = S_LLO;
            S_LLO:   state_d = S_LHI;
            default: begin state_d = S_FIN; issue_d = 1'b0; end
          endcase
        end
      end
      S_FIN: if (!out_valid_q || m_axis_tready) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      n_q         <= 7'd2;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      if (cfg_we_i) begin
        n_q <= cfg_wdata_i;
      end
      if ((state_q == S_FIN) && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      p_q  <= in_pt;
      lo_q <= '0;
      hi_q <= hi_init[AW-1:0];
    end
    if (state_q == S_CMP) begin
      if (rpos > p_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid;
      end
    end
    if (state_q == S_RLO) begin
      xlo_q <= rdata[DW-1:0];
      ylo_q <= rdata[2*DW-1:DW];
      clo_q <= rdata[3*DW-1:2*DW];
    end
    if (state_q == S_RHI) begin
      xhi_q <= rdata[DW-1:0];
      yhi_q <= rdata[2*DW-1:DW];
      chi_q <= rdata[3*DW-1:2*DW];
    end
    if (state_q == S_CHK) begin
      h_q   <= h33[DW-1:0];
      bad_q <= h33[DW] || (h33 == '0);
      sat_q <= 1'b0;
    end
    if (done && !issue_q) begin
      unique case (state_q)
        S_DIVA:  a_q <= sq;
        S_DIVB:  b_q <= sq;
        S_AA, S_BB, S_TLO, S_HH, S_LLO: begin
          m_q   <= fx.val;
          sat_q <= sat_q | fx.sat;
        end
        S_AAA: begin
          ca_q  <= sa.val;
          sat_q <= sat_q | fx.sat | sa.sat;
        end
        S_BBB: begin
          cb_q  <= sa.val;
          sat_q <= sat_q | fx.sat | sa.sat;
        end
        S_THI: begin
          t_q   <= sa.val;
          sat_q <= sat_q | fx.sat | sa.sat;
        end
        S_TH: begin
          t_q   <= fx.val;
          sat_q <= sat_q | fx.sat;
        end
        S_DIV6:  t_q <= sq;
        S_LHI: begin
          m_q   <= sa.val;
          sat_q <= sat_q | fx.sat | sa.sat;
        end
        default: ;
      endcase
    end
    if ((state_q == S_FIN) && (!out_valid_q || m_axis_tready)) begin
      if (bad_q) begin
        out_data_q <= '0;
        out_stat_q <= csse_pkg::ST_WIDTH;
      end else begin
        // final sum, clipped to the 32-bit result range
        if (clamp_hi) begin
          out_data_q <= {1'b0, {(DW-1){1'b1}}};
        end else if (clamp_lo) begin
          out_data_q <= {1'b1, {(DW-1){1'b0}}};
        end else begin
          out_data_q <= sa.val[DW-1:0];
        end
        out_stat_q <= (sat_q || sa.sat || clamp_hi || clamp_lo) ? csse_pkg::ST_SAT
                                                                 : csse_pkg::ST_OK;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule
`default_nettype wire

// ----- hdl/csse_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csse_checker
// Port-level checks of the cubic spline unit, bound to the top level.
// ----------------------------------------------------------------------------
module csse_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [0:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [31:0]  m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser
);

  // a waiting result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a bad interval always reports a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == csse_pkg::ST_WIDTH) |-> (m_axis_tdata == '0))
    else $error("width status with non-zero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == csse_pkg::ST_OK) ||
                      (m_axis_tuser == csse_pkg::ST_WIDTH) ||
                      (m_axis_tuser == csse_pkg::ST_SAT))
    else $error("unknown status code");

  // evaluation keeps the input closed while the search starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == csse_pkg::KIND_EVAL) |=>
      !s_axis_tready)
    else $error("input open during evaluation");

  // a load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == csse_pkg::KIND_LOAD) &&
      !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after load item");

endmodule

bind cubic_spline_evaluator_unit csse_checker u_csse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
